// File: design/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants of the Newton square root block
// Sequencer states, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_DIFF,
    S_TEST,
    S_DIV,
    S_AVG,
    S_FIN
  } nsr_state_t;

  typedef logic [1:0] nsr_status_t;

  localparam nsr_status_t ST_CONVERGED = 2'd0;
  localparam nsr_status_t ST_NEGATIVE  = 2'd1;
  localparam nsr_status_t ST_CAP       = 2'd2;

  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 6;
  localparam int STEP_WIDTH = 6;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_ITERATIONS  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE_SHIFT = 2'd1;

  localparam logic [CFG_DATA_WIDTH-1:0] MAX_ITERATIONS_RST  = 6'd40;
  localparam logic [CFG_DATA_WIDTH-1:0] TOLERANCE_SHIFT_RST = 6'd33;

endpackage

`default_nettype wire

// File: design/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root
// Square root of a signed fixed-point operand by Heron/Newton refinement on
// one shared add/subtract unit.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_x_value
//   out_     output     out_valid / out_ready  out_root_value, out_status,
//                                              out_iterations_used
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every step runs a shift-add square, the difference and test states, a
// restoring divide and an averaging state on the same adder; the square,
// difference and test also run once before the first step. A negative
// operand goes from idle straight to the finishing state. in_ready is high
// only when the sequencer is idle; a finished result waits in the output
// register without blocking the next request. Reset is synchronous and
// active low; the configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_square_root #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  signed [DATA_WIDTH-1:0]          in_x_value,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic        [DATA_WIDTH-2:0]          out_root_value,
  output logic        [1:0]                     out_status,
  output logic        [nsr_pkg::STEP_WIDTH-1:0] out_iterations_used,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire         [nsr_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire         [nsr_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

  // Guess width: holds the operand and the first average of a small operand.
  localparam int WW = (DATA_WIDTH - 1 > FRAC_BITS + 1) ? DATA_WIDTH - 1 : FRAC_BITS + 1;
  // Width of the scaled operand X = x << FRAC_BITS.
  localparam int XW = DATA_WIDTH - 1 + FRAC_BITS;
  localparam int AW = 2 * WW + 2;
  localparam int CW = $clog2(XW);
  localparam int SW = nsr_pkg::STEP_WIDTH;
  localparam logic [CW-1:0] SQ_LAST  = CW'(WW - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(XW - 1);

  nsr_pkg::nsr_state_t state_r, state_nxt;

  logic [nsr_pkg::CFG_DATA_WIDTH-1:0] max_iter_r, max_iter_nxt;
  logic [nsr_pkg::CFG_DATA_WIDTH-1:0] tol_shift_r, tol_shift_nxt;

  logic [XW-1:0]     big_x_r, big_x_nxt;
  logic [XW-1:0]     bound_r, bound_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2*WW-1:0]   prod_r, prod_nxt;
  logic [2*WW-1:0]   mcand_r, mcand_nxt;
  logic [WW-1:0]     mplier_r, mplier_nxt;
  logic [AW-1:0]     diff_r, diff_nxt;
  logic [WW-1:0]     rem_r, rem_nxt;
  logic [XW-1:0]     qd_r, qd_nxt;
  logic [1:0]        stat_r, stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-2:0] out_root_r, out_root_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;
  logic [SW-1:0]     out_iter_r, out_iter_nxt;

  // Shared add/subtract unit.
  logic [AW-1:0]     alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic [WW:0]       rem_sh;
  logic [XW-1:0]     x_scaled;

  assign alu_sum = alu_a + (alu_b ^ {AW{alu_sub}}) + {{(AW-1){1'b0}}, alu_sub};
  assign rem_sh  = {rem_r, qd_r[XW-1]};
  assign x_scaled = XW'({in_x_value[DATA_WIDTH-2:0], {FRAC_BITS{1'b0}}});

  assign in_ready            = (state_r == nsr_pkg::S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_root_value      = out_root_r;
  assign out_status          = out_stat_r;
  assign out_iterations_used = out_iter_r;

  always_comb begin
    max_iter_nxt  = max_iter_r;
    tol_shift_nxt = tol_shift_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsr_pkg::CFG_MAX_ITERATIONS:  max_iter_nxt  = cfg_data;
        nsr_pkg::CFG_TOLERANCE_SHIFT: tol_shift_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    big_x_nxt     = big_x_r;
    bound_nxt     = bound_r;
    w_nxt         = w_r;
    steps_nxt     = steps_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    diff_nxt      = diff_r;
    rem_nxt       = rem_r;
    qd_nxt        = qd_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_root_nxt  = out_root_r;
    out_stat_nxt  = out_stat_r;
    out_iter_nxt  = out_iter_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    case (state_r)
      nsr_pkg::S_IDLE: begin
        if (in_valid) begin
          steps_nxt  = '0;
          cnt_nxt    = '0;
          prod_nxt   = '0;
          big_x_nxt  = x_scaled;
          bound_nxt  = x_scaled >> tol_shift_r;
          w_nxt      = WW'(in_x_value[DATA_WIDTH-2:0]);
          mcand_nxt  = (2*WW)'(in_x_value[DATA_WIDTH-2:0]);
          mplier_nxt = WW'(in_x_value[DATA_WIDTH-2:0]);
          if (in_x_value[DATA_WIDTH-1]) begin
            w_nxt     = '0;
            stat_nxt  = nsr_pkg::ST_NEGATIVE;
            state_nxt = nsr_pkg::S_FIN;
          end else begin
            stat_nxt  = nsr_pkg::ST_CONVERGED;
            state_nxt = nsr_pkg::S_SQ;
          end
        end
      end

      // One partial product per cycle: prod += w << cnt when that bit is set.
      nsr_pkg::S_SQ: begin
        alu_a      = AW'(prod_r);
        alu_b      = AW'(mcand_r);
        if (mplier_r[0]) begin
          prod_nxt = alu_sum[2*WW-1:0];
        end
        mcand_nxt  = {mcand_r[2*WW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[WW-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = nsr_pkg::S_DIFF;
        end
      end

      nsr_pkg::S_DIFF: begin
        alu_a     = AW'(prod_r);
        alu_b     = AW'(big_x_r);
        alu_sub   = 1'b1;
        diff_nxt  = alu_sum;
        state_nxt = nsr_pkg::S_TEST;
      end

      // With d = w*w - X, the error is within bound when bound - d >= 0 for
      // d >= 0, and when bound + d >= 0 for d < 0.
      nsr_pkg::S_TEST: begin
        alu_a   = AW'(bound_r);
        alu_b   = diff_r;
        alu_sub = !diff_r[AW-1];
        if (!alu_sum[AW-1]) begin
          stat_nxt  = nsr_pkg::ST_CONVERGED;
          state_nxt = nsr_pkg::S_FIN;
        end else if (steps_r >= max_iter_r) begin
          stat_nxt  = nsr_pkg::ST_CAP;
          state_nxt = nsr_pkg::S_FIN;
        end else begin
          rem_nxt   = '0;
          qd_nxt    = big_x_r;
          cnt_nxt   = '0;
          state_nxt = nsr_pkg::S_DIV;
        end
      end

      // Restoring division of X by w, one quotient bit per cycle.
      nsr_pkg::S_DIV: begin
        alu_a   = AW'(rem_sh);
        alu_b   = AW'(w_r);
        alu_sub = 1'b1;
        if (alu_sum[AW-1]) begin
          rem_nxt = rem_sh[WW-1:0];
        end else begin
          rem_nxt = alu_sum[WW-1:0];
        end
        qd_nxt  = {qd_r[XW-2:0], !alu_sum[AW-1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = nsr_pkg::S_AVG;
        end
      end

      nsr_pkg::S_AVG: begin
        alu_a      = AW'(w_r);
        alu_b      = AW'(qd_r);
        w_nxt      = alu_sum[WW:1];
        mcand_nxt  = (2*WW)'(alu_sum[WW:1]);
        mplier_nxt = alu_sum[WW:1];
        prod_nxt   = '0;
        steps_nxt  = steps_r + 1'b1;
        state_nxt  = nsr_pkg::S_SQ;
      end

      nsr_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = w_r[DATA_WIDTH-2:0];
          out_stat_nxt  = stat_r;
          out_iter_nxt  = steps_r;
          state_nxt     = nsr_pkg::S_IDLE;
        end
      end

      default: state_nxt = nsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= nsr_pkg::MAX_ITERATIONS_RST;
      tol_shift_r <= nsr_pkg::TOLERANCE_SHIFT_RST;
      w_r         <= '0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      max_iter_r  <= max_iter_nxt;
      tol_shift_r <= tol_shift_nxt;
      w_r         <= w_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    big_x_r    <= big_x_nxt;
    bound_r    <= bound_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    diff_r     <= diff_nxt;
    rem_r      <= rem_nxt;
    qd_r       <= qd_nxt;
    stat_r     <= stat_nxt;
    out_root_r <= out_root_nxt;
    out_stat_r <= out_stat_nxt;
    out_iter_r <= out_iter_nxt;
  end

  // A negative operand reports a zero root and no refinement steps.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nsr_pkg::ST_NEGATIVE
      |-> out_root_value == '0 && out_iterations_used == '0)
    else $error("negative operand result is not cleared");

  // The divisor is never zero while dividing.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nsr_pkg::S_DIV |-> w_r != '0)
    else $error("division by a zero guess");

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != nsr_pkg::S_IDLE)
    else $error("request accepted without starting work");

  // Only defined status codes reach the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == nsr_pkg::ST_CONVERGED || out_status == nsr_pkg::ST_NEGATIVE
                  || out_status == nsr_pkg::ST_CAP)
    else $error("undefined status code on the output");

endmodule

`default_nettype wire
